// ===== design/fcts_pkg.sv =====
// ----------------------------------------------------------------------------
// fcts_pkg
// Shared types, constants and helpers for the four-channel timer unit with
// scanline interrupts.
// ----------------------------------------------------------------------------
`default_nettype none

package fcts_pkg;

	// default timing parameters
	localparam int unsigned LINE_TICKS_DEF    = 515;
	localparam int unsigned DIV1_TICKS_DEF    = 8;
	localparam int unsigned DIV4_TICKS_DEF    = 32;
	localparam int unsigned DIV16_TICKS_DEF   = 128;
	localparam int unsigned DIV256_TICKS_DEF  = 2048;
	localparam int unsigned VISIBLE_LINES_DEF = 152;

	// fixed constants
	localparam logic [7:0]  LAST_LINE      = 8'd198;
	localparam int unsigned T2_FAST_TICKS  = 56;
	localparam logic [2:0]  VINT_MAX_LEVEL = 3'd4;
	localparam logic [2:0]  LEVEL_CAP      = 3'd7;

	// APB address map
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [2:0] {
		REG_RUN_EN   = 3'd0,
		REG_LOW_MODE = 3'd1,
		REG_HIGH_MODE = 3'd2,
		REG_MATCH    = 3'd3,
		REG_PRIO     = 3'd4,
		REG_EV_EN    = 3'd5
	} reg_idx_t;

	// configuration registers as seen by the datapath
	typedef struct packed {
		logic [3:0]  run_en;
		logic [3:0]  low_modes;
		logic [3:0]  high_modes;
		logic [31:0] match_vals;
		logic [14:0] prio;
		logic [2:0]  ev_en;
	} cfg_t;

	// line-unit results handed to the timer stage
	typedef struct packed {
		logic [2:0] level;
		logic       take_comms;
		logic       take_vert;
		logic       line_end;
		logic [7:0] scanline;
		logic       vblank;
		logic [7:0] rx_hold;
		logic       hline_now;
	} line_res_t;

	// one interrupt taken: level rises by one, capped
	function automatic logic [2:0] take_level(input logic [2:0] lvl);
		take_level = (lvl < LEVEL_CAP) ? lvl + 3'd1 : lvl;
	endfunction

endpackage

`default_nettype wire

// ===== design/fcts_cfg.sv =====
// ----------------------------------------------------------------------------
// fcts_cfg
// APB register file: six configuration registers, write and read back.
// ----------------------------------------------------------------------------
`default_nettype none

module fcts_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [fcts_pkg::ADDR_W-1:0] paddr,
	input  wire logic [fcts_pkg::DATA_W-1:0] pwdata,
	output logic      [fcts_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output fcts_pkg::cfg_t                  cfg
);
	import fcts_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_RUN_EN:    cfg_q.run_en     <= pwdata[3:0];
				REG_LOW_MODE:  cfg_q.low_modes  <= pwdata[3:0];
				REG_HIGH_MODE: cfg_q.high_modes <= pwdata[3:0];
				REG_MATCH:     cfg_q.match_vals <= pwdata;
				REG_PRIO:      cfg_q.prio       <= pwdata[14:0];
				REG_EV_EN:     cfg_q.ev_en      <= pwdata[2:0];
				default:       ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_RUN_EN:    prdata = {28'd0, cfg_q.run_en};
			REG_LOW_MODE:  prdata = {28'd0, cfg_q.low_modes};
			REG_HIGH_MODE: prdata = {28'd0, cfg_q.high_modes};
			REG_MATCH:     prdata = cfg_q.match_vals;
			REG_PRIO:      prdata = {17'd0, cfg_q.prio};
			REG_EV_EN:     prdata = {29'd0, cfg_q.ev_en};
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/fcts_line.sv =====
// ----------------------------------------------------------------------------
// fcts_line
// Line accumulator, scanline counter, vblank, pending horizontal tick and
// comms receive latch, with the comms and vertical interrupt checks.
// ----------------------------------------------------------------------------
`default_nettype none

module fcts_line #(
	parameter int unsigned LINE_TICKS    = fcts_pkg::LINE_TICKS_DEF,
	parameter int unsigned VISIBLE_LINES = fcts_pkg::VISIBLE_LINES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        ticks,
	input  wire logic [2:0]        level_in,
	input  wire logic              rx_v,
	input  wire logic [7:0]        rx_b,
	input  wire fcts_pkg::cfg_t    cfg,
	input  wire logic              hline_consume,
	output fcts_pkg::line_res_t    res
);
	import fcts_pkg::*;

	logic [15:0] accum_q;
	logic [7:0]  scan_q;
	logic        vblank_q;
	logic        hline_q;
	logic [7:0]  rx_hold_q;

	logic [16:0] acc_sum;
	logic [15:0] acc_sat;
	logic [15:0] acc_next;
	logic [7:0]  scan_inc;
	logic [2:0]  lvl_a;

	// line accumulation and end-of-line work
	always_comb begin
		acc_sum = {1'b0, accum_q} + {9'd0, ticks};
		acc_sat = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
		acc_next = acc_sat;
		scan_inc = scan_q + 8'd1;
		res = '0;
		res.level = level_in;
		res.scanline = scan_q;
		res.vblank = vblank_q;
		res.rx_hold = rx_hold_q;
		res.hline_now = hline_q;
		lvl_a = level_in;
		if (acc_sat >= 16'(LINE_TICKS)) begin
			res.line_end = 1'b1;
			acc_next = '0;
			// horizontal tick on drawn lines and on the last line
			if ((scan_q < 8'(VISIBLE_LINES - 1) || scan_q == LAST_LINE) && cfg.ev_en[0])
				res.hline_now = 1'b1;
			res.scanline = scan_inc;
			// comms receive
			if (cfg.ev_en[2] && rx_v && level_in <= cfg.prio[14:12]) begin
				res.rx_hold = rx_b;
				res.take_comms = 1'b1;
				lvl_a = take_level(level_in);
			end
			res.level = lvl_a;
			// start of vertical blank
			if (scan_inc == 8'(VISIBLE_LINES)) begin
				res.vblank = 1'b1;
				if (lvl_a <= VINT_MAX_LEVEL && cfg.ev_en[1]) begin
					res.take_vert = 1'b1;
					res.level = take_level(lvl_a);
				end
			end
			// wrap after the last line
			if (scan_q == LAST_LINE) begin
				res.scanline = '0;
				res.vblank = 1'b0;
			end
		end
	end

	// state update per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q   <= '0;
			scan_q    <= '0;
			vblank_q  <= 1'b0;
			hline_q   <= 1'b0;
			rx_hold_q <= '0;
		end else if (step) begin
			accum_q   <= acc_next;
			scan_q    <= res.scanline;
			vblank_q  <= res.vblank;
			hline_q   <= res.hline_now && !hline_consume;
			rx_hold_q <= res.rx_hold;
		end
	end

endmodule

`default_nettype wire

// ===== design/fcts_timer.sv =====
// ----------------------------------------------------------------------------
// fcts_timer
// One 8-bit up-counter with its saturating prescaler and threshold match.
// Mode 0 counts on the fire input; modes 1..3 count on prescaler periods.
// ----------------------------------------------------------------------------
`default_nettype none

module fcts_timer #(
	parameter int unsigned PERIOD1 = fcts_pkg::DIV1_TICKS_DEF,
	parameter int unsigned PERIOD2 = fcts_pkg::DIV16_TICKS_DEF,
	parameter int unsigned PERIOD3 = fcts_pkg::DIV256_TICKS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] ticks,
	input  wire logic       run,
	input  wire logic [1:0] mode,
	input  wire logic       fire,
	input  wire logic [7:0] thresh,
	output logic            match
);
	logic [15:0] pre_q;
	logic [7:0]  up_q;

	logic [16:0] pre_sum;
	logic [15:0] pre_sat;
	logic [15:0] period;
	logic        inc;
	logic [7:0]  up_inc;
	logic [15:0] pre_next;
	logic [7:0]  up_next;

	// prescale, increment, threshold
	always_comb begin
		pre_sum = {1'b0, pre_q} + {9'd0, ticks};
		pre_sat = pre_sum[16] ? 16'hFFFF : pre_sum[15:0];
		case (mode)
			2'd1:    period = 16'(PERIOD1);
			2'd2:    period = 16'(PERIOD2);
			default: period = 16'(PERIOD3);
		endcase
		inc = (mode == 2'd0) ? fire : (pre_sat >= period);
		pre_next = pre_sat;
		up_next = up_q;
		up_inc = up_q;
		match = 1'b0;
		if (run) begin
			if (inc) begin
				up_inc = up_q + 8'd1;
				pre_next = '0;
			end
			match = (thresh != 8'd0) && (up_inc >= thresh);
			up_next = match ? 8'd0 : up_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q <= '0;
			up_q  <= '0;
		end else if (step) begin
			pre_q <= pre_next;
			up_q  <= up_next;
		end
	end

endmodule

`default_nettype wire

// ===== design/four_channel_timer_with_scanline_ints_top.sv =====
// ----------------------------------------------------------------------------
// four_channel_timer_with_scanline_ints_top
// Scanline timing, comms receive and four chained 8-bit timers with
// interrupt level tracking; one result beat per input beat.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | in        | in_valid / in_stall  | cpu_ticks mask_level rx_valid
//          |           |                      | rx_byte
//  out     | out       | out_valid / out_stall| taken_ints new_mask_level
//          |           |                      | match_events sub_cpu_irq ...
//  cfg     | in        | APB psel/penable     | paddr pwdata prdata pready
//
// One beat per cycle while out_stall is low; each beat passes the input register, then the
// line/timer logic into the result register.
// Reset clears all counters, flags and configuration to zero.
// out_stall holds the result register; in_stall rises only when both the
// input and result registers are full and the result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_timer_with_scanline_ints_top #(
	parameter int unsigned LINE_TICKS    = fcts_pkg::LINE_TICKS_DEF,
	parameter int unsigned DIV1_TICKS    = fcts_pkg::DIV1_TICKS_DEF,
	parameter int unsigned DIV4_TICKS    = fcts_pkg::DIV4_TICKS_DEF,
	parameter int unsigned DIV16_TICKS   = fcts_pkg::DIV16_TICKS_DEF,
	parameter int unsigned DIV256_TICKS  = fcts_pkg::DIV256_TICKS_DEF,
	parameter int unsigned VISIBLE_LINES = fcts_pkg::VISIBLE_LINES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// input channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [7:0]                  cpu_ticks,
	input  wire logic [2:0]                  mask_level,
	input  wire logic                        rx_valid,
	input  wire logic [7:0]                  rx_byte,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [5:0]                       taken_ints,
	output logic [2:0]                       new_mask_level,
	output logic [3:0]                       match_events,
	output logic                             sub_cpu_irq,
	output logic [7:0]                       line_number,
	output logic                             vblank_flag,
	output logic                             line_advanced,
	output logic [7:0]                       rx_latched,
	// configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [fcts_pkg::ADDR_W-1:0] paddr,
	input  wire logic [fcts_pkg::DATA_W-1:0] pwdata,
	output logic      [fcts_pkg::DATA_W-1:0] prdata,
	output logic                             pready
);
	import fcts_pkg::*;

	cfg_t      cfg;
	line_res_t lres;

	logic       valid_s1;
	logic [7:0] ticks_s1;
	logic [2:0] mask_s1;
	logic       rxv_s1;
	logic [7:0] rxb_s1;

	logic       valid_s2;
	logic [5:0] taken_s2;
	logic [2:0] level_s2;
	logic [3:0] match_s2;
	logic [7:0] line_s2;
	logic       vblank_s2;
	logic       adv_s2;
	logic [7:0] rx_s2;

	logic       adv;
	logic       step;
	logic       hline_consume;
	logic [3:0] tm;
	logic [2:0] lvl0, lvl1, lvl2, lvl3;
	logic [2:0] lvl_out;
	logic [5:0] taken;

	// handshake
	assign adv      = !valid_s2 || !out_stall;
	assign step     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	fcts_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// timer 0 in horizontal mode eats the pending tick
	assign hline_consume = cfg.run_en[0] && (cfg.low_modes[1:0] == 2'd0) && lres.hline_now;

	fcts_line #(
		.LINE_TICKS    (LINE_TICKS),
		.VISIBLE_LINES (VISIBLE_LINES)
	) u_line (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.ticks         (ticks_s1),
		.level_in      (mask_s1),
		.rx_v          (rxv_s1),
		.rx_b          (rxb_s1),
		.cfg           (cfg),
		.hline_consume (hline_consume),
		.res           (lres)
	);

	fcts_timer #(
		.PERIOD1 (DIV1_TICKS),
		.PERIOD2 (DIV4_TICKS),
		.PERIOD3 (DIV16_TICKS)
	) u_tmr0 (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ticks  (ticks_s1),
		.run    (cfg.run_en[0]),
		.mode   (cfg.low_modes[1:0]),
		.fire   (lres.hline_now),
		.thresh (cfg.match_vals[7:0]),
		.match  (tm[0])
	);

	fcts_timer #(
		.PERIOD1 (DIV1_TICKS),
		.PERIOD2 (DIV16_TICKS),
		.PERIOD3 (DIV256_TICKS)
	) u_tmr1 (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ticks  (ticks_s1),
		.run    (cfg.run_en[1]),
		.mode   (cfg.low_modes[3:2]),
		.fire   (tm[0]),
		.thresh (cfg.match_vals[15:8]),
		.match  (tm[1])
	);

	// mode 0 of timer 2 is stopped: no trigger
	fcts_timer #(
		.PERIOD1 (T2_FAST_TICKS),
		.PERIOD2 (DIV4_TICKS),
		.PERIOD3 (DIV16_TICKS)
	) u_tmr2 (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ticks  (ticks_s1),
		.run    (cfg.run_en[2]),
		.mode   (cfg.high_modes[1:0]),
		.fire   (1'b0),
		.thresh (cfg.match_vals[23:16]),
		.match  (tm[2])
	);

	fcts_timer #(
		.PERIOD1 (DIV1_TICKS),
		.PERIOD2 (DIV16_TICKS),
		.PERIOD3 (DIV256_TICKS)
	) u_tmr3 (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ticks  (ticks_s1),
		.run    (cfg.run_en[3]),
		.mode   (cfg.high_modes[3:2]),
		.fire   (tm[2]),
		.thresh (cfg.match_vals[31:24]),
		.match  (tm[3])
	);

	// timer interrupt chain, each take raising the running level
	always_comb begin
		taken = {4'd0, lres.take_vert, lres.take_comms};
		lvl0 = lres.level;
		lvl1 = lvl0;
		if (tm[0] && lvl0 <= cfg.prio[2:0]) begin
			lvl1 = take_level(lvl0);
			taken[2] = 1'b1;
		end
		lvl2 = lvl1;
		if (tm[1] && lvl1 <= cfg.prio[5:3]) begin
			lvl2 = take_level(lvl1);
			taken[3] = 1'b1;
		end
		lvl3 = lvl2;
		if (tm[2] && lvl2 <= cfg.prio[8:6]) begin
			lvl3 = take_level(lvl2);
			taken[4] = 1'b1;
		end
		lvl_out = lvl3;
		if (tm[3] && lvl3 <= cfg.prio[11:9]) begin
			lvl_out = take_level(lvl3);
			taken[5] = 1'b1;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ticks_s1 <= cpu_ticks;
			mask_s1  <= mask_level;
			rxv_s1   <= rx_valid;
			rxb_s1   <= rx_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			taken_s2  <= taken;
			level_s2  <= lvl_out;
			match_s2  <= tm;
			line_s2   <= lres.scanline;
			vblank_s2 <= lres.vblank;
			adv_s2    <= lres.line_end;
			rx_s2     <= lres.rx_hold;
		end
	end

	assign out_valid      = valid_s2;
	assign taken_ints     = taken_s2;
	assign new_mask_level = level_s2;
	assign match_events   = match_s2;
	assign sub_cpu_irq    = match_s2[3];
	assign line_number    = line_s2;
	assign vblank_flag    = vblank_s2;
	assign line_advanced  = adv_s2;
	assign rx_latched     = rx_s2;

endmodule

`default_nettype wire

// ===== design/fcts_checker.sv =====
// ----------------------------------------------------------------------------
// fcts_checker
// Port-level checks on the result channel of the timer unit, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fcts_checker #(
	parameter int unsigned VISIBLE_LINES = fcts_pkg::VISIBLE_LINES_DEF
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [5:0] taken_ints,
	input wire logic [3:0] match_events,
	input wire logic       sub_cpu_irq,
	input wire logic [7:0] line_number,
	input wire logic       vblank_flag
);
	import fcts_pkg::*;

	// a stalled result beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(taken_ints) && $stable(line_number))
		else $error("result beat changed under stall");

	// scanline stays in range and vblank tracks it
	a_line_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_number <= LAST_LINE
			&& vblank_flag == (line_number >= 8'(VISIBLE_LINES)))
		else $error("scanline or vblank out of step");

	// sub processor pulse follows timer 3 match
	a_sub_irq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sub_cpu_irq == match_events[3])
		else $error("sub irq without timer 3 match");

	// a timer interrupt needs a match in the same beat
	a_taken_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (taken_ints[5:2] & ~match_events) == 4'd0)
		else $error("timer interrupt taken without match");

endmodule

bind four_channel_timer_with_scanline_ints_top fcts_checker #(
	.VISIBLE_LINES (VISIBLE_LINES)
) u_fcts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.taken_ints   (taken_ints),
	.match_events (match_events),
	.sub_cpu_irq  (sub_cpu_irq),
	.line_number  (line_number),
	.vblank_flag  (vblank_flag)
);

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-channel timer unit with scanline
// interrupts. A directed table runs first, then randomized phases, each with
// its own register setting. A beat-level predictor built into the bench
// predicts the untyped beats, typed rows bring their own, and a monitor compares the beats field by field.
// ----------------------------------------------------------------------------

module testbench;
	import fcts_pkg::*;

	// block parameters, left at their defaults on the instance
	localparam int unsigned LINE_TICKS    = LINE_TICKS_DEF;
	localparam int unsigned DIV1_TICKS    = DIV1_TICKS_DEF;
	localparam int unsigned DIV4_TICKS    = DIV4_TICKS_DEF;
	localparam int unsigned DIV16_TICKS   = DIV16_TICKS_DEF;
	localparam int unsigned DIV256_TICKS  = DIV256_TICKS_DEF;
	localparam int unsigned VISIBLE_LINES = VISIBLE_LINES_DEF;

	// clock source codes of a timer's 2-bit mode field
	localparam logic [1:0] SRC_EVENT = 2'd0;	// hline tick, chain or stopped
	localparam logic [1:0] SRC_FAST  = 2'd1;
	localparam logic [1:0] SRC_MID   = 2'd2;
	localparam logic [1:0] SRC_SLOW  = 2'd3;

	// event enable bits and taken-interrupt bits
	localparam int EV_HORIZ   = 0;
	localparam int EV_VERT    = 1;
	localparam int EV_COMMS   = 2;
	localparam int INT_COMMS  = 0;
	localparam int INT_VERT   = 1;
	localparam int INT_TIMER0 = 2;

	// register index past the end of the map
	localparam logic [2:0] REG_UNUSED = 3'd6;

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 8;
	// ~1050 beats, each at worst the longest send gap plus the longest stall, plus the hold-off
	localparam int CYCLE_LIMIT     = 400000;

	typedef struct packed {
		logic [7:0] ticks;
		logic [2:0] mask;
		logic       rx_on;
		logic [7:0] rx_data;
	} tick_beat_t;

	typedef struct packed {
		logic [5:0] taken;
		logic [2:0] level;
		logic [3:0] match_bits;
		logic       sub_irq;
		logic [7:0] line;
		logic       vblank;
		logic       advanced;
		logic [7:0] rx;
	} timer_res_t;

	typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [2:0] sel;
		logic [31:0] value;
		tick_beat_t beat;
		bit         typed;
		timer_res_t want;
	} dir_row_t;

	// DUT connections
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] cpu_ticks = '0;
	logic [2:0] mask_level = '0;
	logic rx_valid = 1'b0;
	logic [7:0] rx_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [5:0] taken_ints;
	logic [2:0] new_mask_level;
	logic [3:0] match_events;
	logic sub_cpu_irq;
	logic [7:0] line_number;
	logic vblank_flag;
	logic line_advanced;
	logic [7:0] rx_latched;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// predictor state and register shadow
	cfg_t cfg_copy = '0;
	logic [15:0] line_acc = '0;
	logic [7:0] cur_line = '0;
	logic vbl_on = 1'b0;
	logic hline_wait = 1'b0;
	logic [15:0] psc_count [4] = '{default: '0};
	logic [7:0] up_cnt [4] = '{default: '0};
	logic [7:0] rx_keep = '0;

	timer_res_t pending_results [$];
	dir_row_t dir_rows [$];
	int mismatch_count = 0;
	int result_count = 0;
	int cycle_count = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	four_channel_timer_with_scanline_ints_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cpu_ticks      (cpu_ticks),
		.mask_level     (mask_level),
		.rx_valid       (rx_valid),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.taken_ints     (taken_ints),
		.new_mask_level (new_mask_level),
		.match_events   (match_events),
		.sub_cpu_irq    (sub_cpu_irq),
		.line_number    (line_number),
		.vblank_flag    (vblank_flag),
		.line_advanced  (line_advanced),
		.rx_latched     (rx_latched),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// one interrupt taken: level up by one, stuck at the cap
	function automatic logic [2:0] step_level(input logic [2:0] l);
		step_level = (l == LEVEL_CAP) ? l : l + 3'd1;
	endfunction

	// predicted result of one beat; advances the predictor state
	function automatic timer_res_t advance_timer_unit(input tick_beat_t b);
		timer_res_t r;
		logic [16:0] sum;
		logic [2:0] lvl;
		logic [1:0] src;
		logic [7:0] th;
		logic [3:0] hit;
		int unsigned period;
		bit fire;
		r = '0;
		hit = '0;
		lvl = b.mask;

		// line accumulator and scanline events
		sum = {1'b0, line_acc} + {9'd0, b.ticks};
		line_acc = (sum > 17'd65535) ? 16'hFFFF : sum[15:0];
		if (line_acc >= 16'(LINE_TICKS)) begin
			r.advanced = 1'b1;
			if ((cur_line < 8'(VISIBLE_LINES - 1) || cur_line == LAST_LINE) &&
					cfg_copy.ev_en[EV_HORIZ])
				hline_wait = 1'b1;
			cur_line = cur_line + 8'd1;
			line_acc = '0;
			if (cfg_copy.ev_en[EV_COMMS] && b.rx_on && lvl <= cfg_copy.prio[14:12]) begin
				rx_keep = b.rx_data;
				lvl = step_level(lvl);
				r.taken[INT_COMMS] = 1'b1;
			end
			if (cur_line == 8'(VISIBLE_LINES)) begin
				vbl_on = 1'b1;
				if (lvl <= VINT_MAX_LEVEL && cfg_copy.ev_en[EV_VERT]) begin
					lvl = step_level(lvl);
					r.taken[INT_VERT] = 1'b1;
				end
			end
			if (cur_line == LAST_LINE + 8'd1) begin
				cur_line = '0;
				vbl_on = 1'b0;
			end
		end

		// prescalers saturate
		for (int n = 0; n < 4; n++) begin
			sum = {1'b0, psc_count[n]} + {9'd0, b.ticks};
			psc_count[n] = (sum > 17'd65535) ? 16'hFFFF : sum[15:0];
		end

		// timers in order, so chaining sees this beat's match
		for (int n = 0; n < 4; n++) begin
			if (cfg_copy.run_en[n]) begin
				src = (n < 2) ? cfg_copy.low_modes[2*(n%2) +: 2] :
					cfg_copy.high_modes[2*(n%2) +: 2];
				if (src == SRC_EVENT) begin
					case (n)
						0: begin
							fire = hline_wait;
							hline_wait = 1'b0;
						end
						1: fire = hit[0];
						2: fire = 1'b0;
						default: fire = hit[2];
					endcase
				end else begin
					case (src)
						SRC_FAST: period = (n == 2) ? T2_FAST_TICKS : DIV1_TICKS;
						SRC_MID:  period = (n % 2) ? DIV16_TICKS : DIV4_TICKS;
						default:  period = (n % 2) ? DIV256_TICKS : DIV16_TICKS;
					endcase
					fire = (psc_count[n] >= 16'(period));
				end
				if (fire) begin
					up_cnt[n] = up_cnt[n] + 8'd1;
					psc_count[n] = '0;
				end
				th = cfg_copy.match_vals[8*n +: 8];
				if (th != 8'd0 && up_cnt[n] >= th) begin
					up_cnt[n] = '0;
					hit[n] = 1'b1;
					if (lvl <= cfg_copy.prio[3*n +: 3]) begin
						lvl = step_level(lvl);
						r.taken[INT_TIMER0 + n] = 1'b1;
					end
				end
			end
		end

		r.match_bits = hit;
		r.sub_irq = hit[3];
		r.level = lvl;
		r.line = cur_line;
		r.vblank = vbl_on;
		r.rx = rx_keep;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on result %0d: %s is %0h, predicted %0h",
			result_count, field, got, want);
		mismatch_count++;
	endtask

	// APB write: setup, then access until pready; shadow follows
	task automatic cfg_write(input logic [2:0] sel, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (sel)
			REG_RUN_EN:    cfg_copy.run_en = value[3:0];
			REG_LOW_MODE:  cfg_copy.low_modes = value[3:0];
			REG_HIGH_MODE: cfg_copy.high_modes = value[3:0];
			REG_MATCH:     cfg_copy.match_vals = value;
			REG_PRIO:      cfg_copy.prio = value[14:0];
			REG_EV_EN:     cfg_copy.ev_en = value[2:0];
			default: ;
		endcase
	endtask

	// stop offering and wait for every predicted beat to come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// offer one beat after a random gap; predict on acceptance
	task automatic send_beat(input tick_beat_t b, input bit typed, input timer_res_t want);
		int gap;
		int r;
		timer_res_t predicted;
		if (calm) begin
			gap = 0;
		end else begin
			r = $urandom_range(0, 99);
			gap = (r < 55) ? 0 : ((r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40));
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cpu_ticks <= b.ticks;
		mask_level <= b.mask;
		rx_valid <= b.rx_on;
		rx_byte <= b.rx_data;
		do @(posedge clk); while (in_stall);
		predicted = advance_timer_unit(b);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic add_write(input logic [2:0] sel, input logic [31:0] value);
		dir_row_t row;
		row = '{kind: ROW_WRITE, sel: sel, value: value, beat: '0, typed: 1'b0, want: '0};
		dir_rows.push_back(row);
	endtask

	task automatic add_beat(input logic [7:0] t, input logic [2:0] m, input logic rv,
			input logic [7:0] rb);
		dir_row_t row;
		row = '{kind: ROW_BEAT, sel: '0, value: '0, beat: {t, m, rv, rb}, typed: 1'b0,
			want: '0};
		dir_rows.push_back(row);
	endtask

	// rows with every interrupt off: only level, line and line end move
	task automatic add_typed(input logic [7:0] t, input logic [2:0] m, input logic rv,
			input logic [7:0] rb, input logic [7:0] ln, input logic adv);
		dir_row_t row;
		row = '{kind: ROW_BEAT, sel: '0, value: '0, beat: {t, m, rv, rb}, typed: 1'b1,
			want: '0};
		row.want.level = m;
		row.want.line = ln;
		row.want.advanced = adv;
		dir_rows.push_back(row);
	endtask

	// result monitor
	always @(posedge clk) begin
		timer_res_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("beat with none predicted", 32'd1, 32'd0);
			end else begin
				w = pending_results.pop_front();
				if (taken_ints !== w.taken)
					report_mismatch("taken_ints", 32'(taken_ints), 32'(w.taken));
				if (new_mask_level !== w.level)
					report_mismatch("new_mask_level", 32'(new_mask_level), 32'(w.level));
				if (match_events !== w.match_bits)
					report_mismatch("match_events", 32'(match_events), 32'(w.match_bits));
				if (sub_cpu_irq !== w.sub_irq)
					report_mismatch("sub_cpu_irq", 32'(sub_cpu_irq), 32'(w.sub_irq));
				if (line_number !== w.line)
					report_mismatch("line_number", 32'(line_number), 32'(w.line));
				if (vblank_flag !== w.vblank)
					report_mismatch("vblank_flag", 32'(vblank_flag), 32'(w.vblank));
				if (line_advanced !== w.advanced)
					report_mismatch("line_advanced", 32'(line_advanced), 32'(w.advanced));
				if (rx_latched !== w.rx)
					report_mismatch("rx_latched", 32'(rx_latched), 32'(w.rx));
			end
			result_count++;
		end
	end

	// receiver back-pressure: random bursts, a long hold-off on request
	initial begin
		int r;
		int len;
		int hold_cnt;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
					@(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					out_stall <= 1'b0;
					len = $urandom_range(1, 8);
				end else if (r < 85) begin
					out_stall <= 1'b1;
					len = $urandom_range(1, 3);
				end else begin
					out_stall <= 1'b1;
					len = $urandom_range(10, 60);
				end
				repeat (len - 1) @(posedge clk);
			end
		end
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// stimulus
	initial begin
		int phase;
		int k;
		int r;
		tick_beat_t b;
		timer_res_t none;
		logic [3:0] run_v;
		logic [3:0] lo_v;
		logic [3:0] hi_v;
		logic [31:0] match_v;
		logic [14:0] prio_v;
		logic [2:0] ev_v;
		none = '0;

		// directed: reset state, unmapped write, first line end
		add_typed(8'd0, 3'd0, 1'b0, 8'h00, 8'd0, 1'b0);
		add_typed(8'hFF, 3'd7, 1'b1, 8'hFF, 8'd0, 1'b0);
		add_write(REG_UNUSED, 32'hFFFF_FFFF);
		add_typed(8'hFF, 3'd2, 1'b1, 8'h5A, 8'd0, 1'b0);
		add_typed(8'd5, 3'd5, 1'b0, 8'h00, 8'd1, 1'b1);
		// everything on: hline clock, chains, fast timer 2, low thresholds
		add_write(REG_EV_EN, 32'h7);
		add_write(REG_PRIO, 32'h7FFF);
		add_write(REG_RUN_EN, 32'hF);
		add_write(REG_LOW_MODE, {28'd0, SRC_EVENT, SRC_EVENT});
		add_write(REG_HIGH_MODE, {28'd0, SRC_EVENT, SRC_FAST});
		add_write(REG_MATCH, 32'h0201_0301);
		add_beat(8'hFF, 3'd0, 1'b1, 8'hFF);
		add_beat(8'hFF, 3'd7, 1'b1, 8'h00);
		add_beat(8'hFF, 3'd3, 1'b0, 8'h11);
		add_beat(8'd0, 3'd0, 1'b1, 8'h22);
		add_beat(8'd200, 3'd1, 1'b1, 8'h33);
		add_beat(8'hFF, 3'd6, 1'b1, 8'h44);
		add_beat(8'd100, 3'd0, 1'b0, 8'h00);
		// slowest prescalers, top thresholds, lowest priority
		add_write(REG_LOW_MODE, {28'd0, SRC_SLOW, SRC_SLOW});
		add_write(REG_HIGH_MODE, {28'd0, SRC_SLOW, SRC_SLOW});
		add_write(REG_MATCH, 32'hFFFF_FFFF);
		add_write(REG_PRIO, 32'h0);
		add_beat(8'hFF, 3'd0, 1'b1, 8'h81);
		add_beat(8'hFF, 3'd1, 1'b1, 8'h7E);
		add_beat(8'hFF, 3'd0, 1'b1, 8'hC3);
		add_beat(8'd60, 3'd0, 1'b0, 8'h00);
		// thresholds off
		add_write(REG_MATCH, 32'h0);
		add_beat(8'hFF, 3'd4, 1'b1, 8'h0F);
		add_beat(8'hFF, 3'd0, 1'b0, 8'h00);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				wait_idle();
				cfg_write(dir_rows[i].sel, dir_rows[i].value);
			end else begin
				send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// random phases, one register setting each; line state carries over
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			wait_idle();
			calm = 1'b0;
			if (phase == 1) begin
				run_v = 4'hF;
				lo_v = 4'hF;
				hi_v = 4'hF;
				match_v = 32'hFFFF_FFFF;
				prio_v = 15'h7FFF;
				ev_v = 3'h7;
			end else if (phase == NUM_PHASES - 1) begin
				run_v = '0;
				lo_v = '0;
				hi_v = '0;
				match_v = '0;
				prio_v = '0;
				ev_v = '0;
			end else begin
				run_v = ($urandom_range(0, 9) < 7) ? 4'hF : 4'($urandom_range(0, 15));
				lo_v = 4'($urandom_range(0, 15));
				hi_v = 4'($urandom_range(0, 15));
				for (k = 0; k < 4; k++) begin
					r = $urandom_range(0, 9);
					match_v[8*k +: 8] = (r < 2) ? 8'd0 :
						((r < 8) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(0, 255)));
				end
				prio_v = 15'($urandom_range(0, 32767));
				ev_v = ($urandom_range(0, 9) < 6) ? 3'h7 : 3'($urandom_range(0, 7));
			end
			cfg_write(REG_RUN_EN, {28'd0, run_v});
			cfg_write(REG_LOW_MODE, {28'd0, lo_v});
			cfg_write(REG_HIGH_MODE, {28'd0, hi_v});
			cfg_write(REG_MATCH, match_v);
			cfg_write(REG_PRIO, {17'd0, prio_v});
			cfg_write(REG_EV_EN, {29'd0, ev_v});

			calm = (phase == 3);
			if (phase == 2)
				hold_req = 1'b1;

			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				// sender pause until the pipe is empty
				if (phase == 4 && k == ITEMS_PER_PHASE / 2)
					wait_idle();
				// big tick counts dominate so the frame wraps within the run
				r = $urandom_range(0, 99);
				if (r < 70)
					b.ticks = 8'($urandom_range(160, 255));
				else if (r < 90)
					b.ticks = 8'($urandom_range(0, 255));
				else if (r < 95)
					b.ticks = 8'd0;
				else
					b.ticks = 8'hFF;
				b.mask = $urandom_range(0, 1) ? 3'($urandom_range(0, 2)) :
					3'($urandom_range(0, 7));
				b.rx_on = 1'($urandom_range(0, 1));
				b.rx_data = 8'($urandom_range(0, 255));
				send_beat(b, 1'b0, none);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
